### src/virtqueue_desc_chain_manager_defines.svh
// Assertion macros shared by the checker of the descriptor chain manager.
// No dependencies; clock and reset are taken as clk and rst_n.
`ifndef VIRTQUEUE_DESC_CHAIN_MANAGER_DEFINES_SVH
`define VIRTQUEUE_DESC_CHAIN_MANAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VDCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vdcm_pkg.sv
// Package of the virtqueue descriptor chain manager: widths, codes, types.
// No dependencies.
package vdcm_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int SLOT_W    = 3;
    localparam int ADDR_W    = 64;
    localparam int SECTOR_W  = 31;
    localparam int RING_W    = 16;
    localparam int LEN_W     = 10;
    localparam int FLAGS_W   = 2;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int HDR_SHIFT = 4;

    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_BASE = 1'b1;

    localparam logic [FLAGS_W-1:0] DESC_F_NEXT  = 2'b01;
    localparam logic [FLAGS_W-1:0] DESC_F_WRITE = 2'b10;

    localparam logic BLK_T_IN  = 1'b0;
    localparam logic BLK_T_OUT = 1'b1;

    localparam logic [LEN_W-1:0] SECTOR_BYTES = 10'd512;
    localparam logic [LEN_W-1:0] HDR_BYTES    = 10'd16;
    localparam logic [LEN_W-1:0] STATUS_BYTES = 10'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_DESC       = 3'd0,
        KIND_AVAIL      = 3'd1,
        KIND_NOTIFY     = 3'd2,
        KIND_REFUSED    = 3'd3,
        KIND_COMPLETION = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_H,
        ST_FIND_D,
        ST_FIND_S,
        ST_HDR,
        ST_DATA,
        ST_STAT,
        ST_AVAIL,
        ST_NOTIFY,
        ST_WALK,
        ST_CPL
    } state_t;

    typedef struct packed {
        logic restart;
        logic pick;
        logic commit;
        logic free;
    } fm_cmd_t;

endpackage

### src/vdcm_desc_mem.sv
// Descriptor memory holding the next index and flags of every descriptor.
// One write port and one read port, read data registered. No dependencies.
module vdcm_desc_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 5,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/vdcm_free_map.sv
// Free-descriptor map with a lowest-free search and a pending pick mask.
// Depends on vdcm_pkg.
module vdcm_free_map
    import vdcm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fm_cmd_t          cmd,
    input  logic [IDX_W-1:0] free_idx,
    output logic             found,
    output logic [IDX_W-1:0] found_idx
);

    logic [DEPTH-1:0] free_reg;
    logic [DEPTH-1:0] free_next;
    logic [DEPTH-1:0] pick_reg;
    logic [DEPTH-1:0] pick_next;
    logic [DEPTH-1:0] avail_bits;
    logic [DEPTH-1:0] lowest;

    assign avail_bits = free_reg & ~pick_reg;
    assign lowest     = avail_bits & (~avail_bits + DEPTH'(1));
    assign found      = |avail_bits;

    always_comb
    begin
        found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (avail_bits[i])
            begin
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        pick_next = pick_reg;
        free_next = free_reg;
        if (cmd.restart)
        begin
            pick_next = '0;
        end
        else if (cmd.pick)
        begin
            pick_next = pick_reg | lowest;
        end
        if (cmd.commit)
        begin
            free_next = free_reg & ~pick_reg;
        end
        if (cmd.free)
        begin
            free_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            pick_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            pick_reg <= pick_next;
        end
    end

endmodule

### src/virtqueue_desc_chain_manager.sv
// Top level of the virtqueue descriptor chain manager for one-sector block requests.
// Depends on vdcm_pkg, vdcm_free_map and vdcm_desc_mem.
//
// Channel   Handshake                 Payload
// command   start, busy               func, buffer_addr, sector, is_write,
//                                     head_index, used_idx, disk_status
// result    result_valid (strobe)     kind, slot, addr, length, flags, next_slot,
//                                     req_type, req_sector, ok, ring_index, last
// config    cfg_we                    cfg_index, cfg_data
//
// A submit keeps busy high through three free-descriptor search states, one per
// descriptor, then five results on consecutive cycles; a refused submit ends after
// the first search state that finds no free descriptor, with a single result.
// A completion keeps busy high through one walk step per descriptor walked and the
// completion state; each step waits for the registered descriptor memory read.
// Reset frees every descriptor at once; there is no clearing pass.
// The receiver cannot stall; every result is shown for exactly one cycle.
module virtqueue_desc_chain_manager
    import vdcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [ADDR_W-1:0]    buffer_addr,
    input  logic [SECTOR_W-1:0]  sector,
    input  logic                 is_write,
    input  logic [SLOT_W-1:0]    head_index,
    input  logic [RING_W-1:0]    used_idx,
    input  logic [STATUS_W-1:0]  disk_status,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    kind,
    output logic [SLOT_W-1:0]    slot,
    output logic [ADDR_W-1:0]    addr,
    output logic [LEN_W-1:0]     length,
    output logic [FLAGS_W-1:0]   flags,
    output logic [SLOT_W-1:0]    next_slot,
    output logic                 req_type,
    output logic [SECTOR_W-1:0]  req_sector,
    output logic                 ok,
    output logic [RING_W-1:0]    ring_index,
    output logic                 last
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ENTRY_W = IDX_W + FLAGS_W;
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(QUEUE_DEPTH - 1);

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0]   hdr_base_reg;
    logic [ADDR_W-1:0]   hdr_base_next;
    logic [ADDR_W-1:0]   stat_base_reg;
    logic [ADDR_W-1:0]   stat_base_next;
    logic [RING_W-1:0]   avail_index_reg;
    logic [RING_W-1:0]   avail_index_next;
    logic [IDX_W-1:0]    avail_slot_reg;
    logic [IDX_W-1:0]    avail_slot_next;
    logic [RING_W-1:0]   last_used_reg;
    logic [RING_W-1:0]   last_used_next;

    logic [ADDR_W-1:0]   buf_reg;
    logic [ADDR_W-1:0]   buf_next;
    logic [SECTOR_W-1:0] sector_reg;
    logic [SECTOR_W-1:0] sector_next;
    logic                write_reg;
    logic                write_next;
    logic [SLOT_W-1:0]   head_reg;
    logic [SLOT_W-1:0]   head_next;
    logic                ok_reg;
    logic                ok_next;
    logic [IDX_W-1:0]    h_reg;
    logic [IDX_W-1:0]    h_next;
    logic [IDX_W-1:0]    d_reg;
    logic [IDX_W-1:0]    d_next;
    logic [IDX_W-1:0]    s_reg;
    logic [IDX_W-1:0]    s_next;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    cur_next;
    logic [IDX_W-1:0]    step_reg;
    logic [IDX_W-1:0]    step_next;

    logic                valid_reg;
    logic                valid_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [KIND_W-1:0]   kind_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    length_next;
    logic [FLAGS_W-1:0]  flags_reg;
    logic [FLAGS_W-1:0]  flags_next;
    logic [SLOT_W-1:0]   nslot_reg;
    logic [SLOT_W-1:0]   nslot_next;
    logic                rtype_reg;
    logic                rtype_next;
    logic [SECTOR_W-1:0] rsector_reg;
    logic [SECTOR_W-1:0] rsector_next;
    logic                rok_reg;
    logic                rok_next;
    logic [RING_W-1:0]   ring_reg;
    logic [RING_W-1:0]   ring_next;
    logic                last_reg;
    logic                last_next;

    logic                accept;
    logic                head_in_range;
    logic                found;
    logic [IDX_W-1:0]    found_idx;
    fm_cmd_t             fm_cmd;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;
    logic [IDX_W-1:0]    walk_nx;
    logic [FLAGS_W-1:0]  walk_fl;
    logic                walk_more;
    logic [FLAGS_W-1:0]  data_flags;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign head_in_range = (32'(head_index) < QUEUE_DEPTH);
    assign walk_nx       = mem_rdata[ENTRY_W-1:FLAGS_W];
    assign walk_fl       = mem_rdata[FLAGS_W-1:0];
    assign walk_more     = ((walk_fl & DESC_F_NEXT) != '0)
                           && ({1'b0, walk_nx} < CNT_W'(QUEUE_DEPTH))
                           && (step_reg != STEP_LAST);
    assign data_flags    = DESC_F_NEXT | (write_reg ? '0 : DESC_F_WRITE);

    vdcm_free_map #(
        .DEPTH (QUEUE_DEPTH)
    ) u_free_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fm_cmd),
        .free_idx  (cur_reg),
        .found     (found),
        .found_idx (found_idx)
    );

    vdcm_desc_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_desc_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_SUBMIT)
                    begin
                        state_next = ST_FIND_H;
                    end
                    else if (head_in_range)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_CPL;
                    end
                end
            end
            ST_FIND_H:
            begin
                state_next = found ? ST_FIND_D : ST_IDLE;
            end
            ST_FIND_D:
            begin
                state_next = found ? ST_FIND_S : ST_IDLE;
            end
            ST_FIND_S:
            begin
                state_next = found ? ST_HDR : ST_IDLE;
            end
            ST_HDR:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                state_next = ST_STAT;
            end
            ST_STAT:
            begin
                state_next = ST_AVAIL;
            end
            ST_AVAIL:
            begin
                state_next = ST_NOTIFY;
            end
            ST_NOTIFY:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                state_next = walk_more ? ST_WALK : ST_CPL;
            end
            ST_CPL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hdr_base_next    = hdr_base_reg;
        stat_base_next   = stat_base_reg;
        avail_index_next = avail_index_reg;
        avail_slot_next  = avail_slot_reg;
        last_used_next   = last_used_reg;
        buf_next         = buf_reg;
        sector_next      = sector_reg;
        write_next       = write_reg;
        head_next        = head_reg;
        ok_next          = ok_reg;
        h_next           = h_reg;
        d_next           = d_reg;
        s_next           = s_reg;
        cur_next         = cur_reg;
        step_next        = step_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_BASE: hdr_base_next  = cfg_data;
                REG_STATUS_BASE: stat_base_next = cfg_data;
                default:         hdr_base_next  = hdr_base_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    buf_next    = buffer_addr;
                    sector_next = sector;
                    write_next  = is_write;
                    head_next   = head_index;
                    ok_next     = (disk_status == '0);
                    cur_next    = IDX_W'(head_index);
                    step_next   = '0;
                    if (func == FUNC_COMPLETE)
                    begin
                        last_used_next = used_idx;
                    end
                end
            end
            ST_FIND_H:
            begin
                h_next = found_idx;
            end
            ST_FIND_D:
            begin
                d_next = found_idx;
            end
            ST_FIND_S:
            begin
                s_next = found_idx;
            end
            ST_NOTIFY:
            begin
                avail_index_next = avail_index_reg + RING_W'(1);
                if ((avail_index_reg == '1) || (avail_slot_reg == STEP_LAST))
                begin
                    avail_slot_next = '0;
                end
                else
                begin
                    avail_slot_next = avail_slot_reg + IDX_W'(1);
                end
            end
            ST_WALK:
            begin
                cur_next  = walk_nx;
                step_next = step_reg + IDX_W'(1);
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_comb
    begin
        valid_next   = 1'b0;
        kind_next    = KIND_DESC;
        slot_next    = '0;
        addr_next    = '0;
        length_next  = '0;
        flags_next   = '0;
        nslot_next   = '0;
        rtype_next   = 1'b0;
        rsector_next = '0;
        rok_next     = 1'b0;
        ring_next    = '0;
        last_next    = 1'b0;
        fm_cmd       = '0;
        mem_we       = 1'b0;
        mem_waddr    = h_reg;
        mem_wdata    = '0;
        mem_raddr    = (state_reg == ST_WALK) ? walk_nx : IDX_W'(head_index);

        case (state_reg)
            ST_IDLE:
            begin
                fm_cmd.restart = 1'b1;
            end
            ST_FIND_H, ST_FIND_D, ST_FIND_S:
            begin
                if (found)
                begin
                    fm_cmd.pick = 1'b1;
                end
                else
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_REFUSED;
                    last_next  = 1'b1;
                end
            end
            ST_HDR:
            begin
                fm_cmd.commit = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = h_reg;
                mem_wdata     = {d_reg, DESC_F_NEXT};
                valid_next    = 1'b1;
                slot_next     = SLOT_W'(h_reg);
                addr_next     = hdr_base_reg + (ADDR_W'(h_reg) << HDR_SHIFT);
                length_next   = HDR_BYTES;
                flags_next    = DESC_F_NEXT;
                nslot_next    = SLOT_W'(d_reg);
                rtype_next    = write_reg ? BLK_T_OUT : BLK_T_IN;
                rsector_next  = sector_reg;
            end
            ST_DATA:
            begin
                mem_we      = 1'b1;
                mem_waddr   = d_reg;
                mem_wdata   = {s_reg, data_flags};
                valid_next  = 1'b1;
                slot_next   = SLOT_W'(d_reg);
                addr_next   = buf_reg;
                length_next = SECTOR_BYTES;
                flags_next  = data_flags;
                nslot_next  = SLOT_W'(s_reg);
            end
            ST_STAT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = s_reg;
                mem_wdata   = {IDX_W'(0), DESC_F_WRITE};
                valid_next  = 1'b1;
                slot_next   = SLOT_W'(s_reg);
                addr_next   = stat_base_reg + ADDR_W'(h_reg);
                length_next = STATUS_BYTES;
                flags_next  = DESC_F_WRITE;
            end
            ST_AVAIL:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_AVAIL;
                slot_next  = SLOT_W'(avail_slot_reg);
                nslot_next = SLOT_W'(h_reg);
            end
            ST_NOTIFY:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_NOTIFY;
                ring_next  = avail_index_reg + RING_W'(1);
                last_next  = 1'b1;
            end
            ST_WALK:
            begin
                fm_cmd.free = 1'b1;
            end
            ST_CPL:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_COMPLETION;
                slot_next  = head_reg;
                rok_next   = ok_reg;
                ring_next  = last_used_reg;
                last_next  = 1'b1;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hdr_base_reg    <= '0;
            stat_base_reg   <= '0;
            avail_index_reg <= '0;
            avail_slot_reg  <= '0;
            last_used_reg   <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            hdr_base_reg    <= hdr_base_next;
            stat_base_reg   <= stat_base_next;
            avail_index_reg <= avail_index_next;
            avail_slot_reg  <= avail_slot_next;
            last_used_reg   <= last_used_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg     <= buf_next;
        sector_reg  <= sector_next;
        write_reg   <= write_next;
        head_reg    <= head_next;
        ok_reg      <= ok_next;
        h_reg       <= h_next;
        d_reg       <= d_next;
        s_reg       <= s_next;
        cur_reg     <= cur_next;
        step_reg    <= step_next;
        kind_reg    <= kind_next;
        slot_reg    <= slot_next;
        addr_reg    <= addr_next;
        length_reg  <= length_next;
        flags_reg   <= flags_next;
        nslot_reg   <= nslot_next;
        rtype_reg   <= rtype_next;
        rsector_reg <= rsector_next;
        rok_reg     <= rok_next;
        ring_reg    <= ring_next;
        last_reg    <= last_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign addr         = addr_reg;
    assign length       = length_reg;
    assign flags        = flags_reg;
    assign next_slot    = nslot_reg;
    assign req_type     = rtype_reg;
    assign req_sector   = rsector_reg;
    assign ok           = rok_reg;
    assign ring_index   = ring_reg;
    assign last         = last_reg;

endmodule

### src/vdcm_checker.sv
// Port-level checker for the descriptor chain manager, bound to the top level.
// Depends on vdcm_pkg and virtqueue_desc_chain_manager_defines.svh.
`include "virtqueue_desc_chain_manager_defines.svh"

module vdcm_checker
    import vdcm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 result_valid,
    input logic [KIND_W-1:0]    kind,
    input logic [SLOT_W-1:0]    slot,
    input logic [ADDR_W-1:0]    addr,
    input logic [LEN_W-1:0]     length,
    input logic [FLAGS_W-1:0]   flags,
    input logic [RING_W-1:0]    ring_index,
    input logic                 last
);

    `VDCM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `VDCM_ASSERT_NEXT(a_results_contiguous, result_valid && !last, result_valid, "gap between the results of one transaction")
    `VDCM_ASSERT_NEXT(a_data_then_status, result_valid && (kind == KIND_DESC) && (length == SECTOR_BYTES), result_valid && (kind == KIND_DESC) && (length == STATUS_BYTES) && (flags == DESC_F_WRITE), "data descriptor not followed by status descriptor")
    `VDCM_ASSERT_NOW(a_refused_clean, result_valid && (kind == KIND_REFUSED), last && (slot == '0) && (addr == '0) && (ring_index == '0), "refused result is not a clean final result")
    `VDCM_ASSERT_NOW(a_notify_last, result_valid && ((kind == KIND_NOTIFY) || (kind == KIND_COMPLETION)), last, "notify or completion not marked last")

endmodule

bind virtqueue_desc_chain_manager vdcm_checker u_vdcm_checker (.*);

### test/tb_virtqueue_desc_chain_manager.sv
`timescale 1ns / 1ps
// Self-checking testbench for the virtqueue descriptor chain manager: directed table, then
// random submit and complete transactions checked against a predictor of the descriptor table.
// Depends on vdcm_pkg and virtqueue_desc_chain_manager.
module tb_virtqueue_desc_chain_manager;
    import vdcm_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    typedef struct {
        logic                func;
        logic [ADDR_W-1:0]   buf_addr;
        logic [SECTOR_W-1:0] sec;
        logic                wr;
        logic [SLOT_W-1:0]   head;
        logic [RING_W-1:0]   used;
        logic [STATUS_W-1:0] st;
    } blk_cmd_t;

    typedef struct {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        logic [FLAGS_W-1:0]  flg;
        logic [SLOT_W-1:0]   nxt;
        logic                rtype;
        logic [SECTOR_W-1:0] rsec;
        logic                ok_bit;
        logic [RING_W-1:0]   ring;
        logic                fin;
    } blk_res_t;

    typedef struct {
        blk_cmd_t cmd;
        logic     fixed;
        blk_res_t res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 start;
    logic                 busy;
    logic                 func;
    logic [ADDR_W-1:0]    buffer_addr;
    logic [SECTOR_W-1:0]  sector;
    logic                 is_write;
    logic [SLOT_W-1:0]    head_index;
    logic [RING_W-1:0]    used_idx;
    logic [STATUS_W-1:0]  disk_status;
    logic                 result_valid;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    addr;
    logic [LEN_W-1:0]     length;
    logic [FLAGS_W-1:0]   flags;
    logic [SLOT_W-1:0]    next_slot;
    logic                 req_type;
    logic [SECTOR_W-1:0]  req_sector;
    logic                 ok;
    logic [RING_W-1:0]    ring_index;
    logic                 last;

    logic [ADDR_W-1:0]    hdr_base;
    logic [ADDR_W-1:0]    stat_base;
    logic [7:0]           desc_free;
    logic [7:0]           desc_written;
    logic [SLOT_W-1:0]    desc_link [QUEUE_DEPTH_DEF];
    logic [FLAGS_W-1:0]   desc_mark [QUEUE_DEPTH_DEF];
    logic [RING_W-1:0]    avail_cnt;
    logic [RING_W-1:0]    used_seen;

    blk_res_t             due_results [$];
    logic [SLOT_W-1:0]    live_heads [$];
    stim_row_t            dir_rows [$];
    blk_res_t             want_res;
    blk_res_t             none_res;
    blk_res_t             cur_fixed_res;
    logic                 cur_fixed = 1'b0;
    logic                 took = 1'b0;
    int                   fault_count = 0;
    int                   cycle_count = 0;

    virtqueue_desc_chain_manager i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .buffer_addr (buffer_addr),
        .sector      (sector),
        .is_write    (is_write),
        .head_index  (head_index),
        .used_idx    (used_idx),
        .disk_status (disk_status),
        .result_valid(result_valid),
        .kind        (kind),
        .slot        (slot),
        .addr        (addr),
        .length      (length),
        .flags       (flags),
        .next_slot   (next_slot),
        .req_type    (req_type),
        .req_sector  (req_sector),
        .ok          (ok),
        .ring_index  (ring_index),
        .last        (last)
    );

    always #1ns clk = ~clk;

    function automatic blk_res_t mk_res(kind_t k, logic [SLOT_W-1:0] sl, logic [ADDR_W-1:0] ad,
                                        logic [LEN_W-1:0] ln, logic [FLAGS_W-1:0] fl,
                                        logic [SLOT_W-1:0] nx, logic ty,
                                        logic [SECTOR_W-1:0] se, logic okb,
                                        logic [RING_W-1:0] rg, logic ls);
        blk_res_t r;
        r.kind   = k;
        r.slot   = sl;
        r.addr   = ad;
        r.len    = ln;
        r.flg    = fl;
        r.nxt    = nx;
        r.rtype  = ty;
        r.rsec   = se;
        r.ok_bit = okb;
        r.ring   = rg;
        r.fin    = ls;
        return r;
    endfunction

    function automatic blk_cmd_t mk_cmd(logic fn, logic [ADDR_W-1:0] ba, logic [SECTOR_W-1:0] se,
                                        logic w, logic [SLOT_W-1:0] hd, logic [RING_W-1:0] us,
                                        logic [STATUS_W-1:0] ds);
        blk_cmd_t c;
        c.func     = fn;
        c.buf_addr = ba;
        c.sec      = se;
        c.wr       = w;
        c.head     = hd;
        c.used     = us;
        c.st       = ds;
        return c;
    endfunction

    task automatic add_row(input blk_cmd_t c, input logic fx, input blk_res_t r);
        stim_row_t row;
        row.cmd   = c;
        row.fixed = fx;
        row.res   = r;
        dir_rows.push_back(row);
    endtask

    task automatic predict_request(input blk_cmd_t c);
        int                 pick [3];
        int                 n;
        int                 idx;
        logic [SLOT_W-1:0]  h;
        logic [SLOT_W-1:0]  d;
        logic [SLOT_W-1:0]  s;
        logic [FLAGS_W-1:0] dfl;
        if (c.func == FUNC_SUBMIT) begin
            n = 0;
            for (int i = 0; i < QUEUE_DEPTH_DEF && n < 3; i++) begin
                if (desc_free[i]) begin
                    pick[n] = i;
                    n++;
                end
            end
            if (n < 3) begin
                due_results.push_back(mk_res(KIND_REFUSED, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0,
                                             '0, 1'b1));
            end
            else begin
                h   = SLOT_W'(pick[0]);
                d   = SLOT_W'(pick[1]);
                s   = SLOT_W'(pick[2]);
                dfl = c.wr ? DESC_F_NEXT : (DESC_F_NEXT | DESC_F_WRITE);
                desc_free[h] = 1'b0;
                desc_free[d] = 1'b0;
                desc_free[s] = 1'b0;
                desc_written[h] = 1'b1;
                desc_written[d] = 1'b1;
                desc_written[s] = 1'b1;
                desc_link[h] = d;
                desc_mark[h] = DESC_F_NEXT;
                desc_link[d] = s;
                desc_mark[d] = dfl;
                desc_link[s] = '0;
                desc_mark[s] = DESC_F_WRITE;
                due_results.push_back(mk_res(KIND_DESC, h, hdr_base + (64'(h) << HDR_SHIFT),
                                             HDR_BYTES, DESC_F_NEXT, d,
                                             c.wr ? BLK_T_OUT : BLK_T_IN, c.sec, 1'b0, '0,
                                             1'b0));
                due_results.push_back(mk_res(KIND_DESC, d, c.buf_addr, SECTOR_BYTES, dfl, s,
                                             1'b0, '0, 1'b0, '0, 1'b0));
                due_results.push_back(mk_res(KIND_DESC, s, stat_base + 64'(h), STATUS_BYTES,
                                             DESC_F_WRITE, '0, 1'b0, '0, 1'b0, '0, 1'b0));
                due_results.push_back(mk_res(KIND_AVAIL, SLOT_W'(avail_cnt % QUEUE_DEPTH_DEF),
                                             '0, '0, '0, h, 1'b0, '0, 1'b0, '0, 1'b0));
                avail_cnt = avail_cnt + 1'b1;
                due_results.push_back(mk_res(KIND_NOTIFY, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0,
                                             avail_cnt, 1'b1));
                live_heads.push_back(h);
            end
        end
        else begin
            used_seen = c.used;
            idx = int'(c.head);
            for (int k = 0; k < QUEUE_DEPTH_DEF; k++) begin
                desc_free[idx] = 1'b1;
                if ((desc_mark[idx] & DESC_F_NEXT) == '0)
                    break;
                idx = int'(desc_link[idx]);
            end
            due_results.push_back(mk_res(KIND_COMPLETION, c.head, '0, '0, '0, '0, 1'b0, '0,
                                         c.st == '0, used_seen, 1'b1));
        end
    endtask

    task automatic cmp_field(input string nm, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", nm, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == REG_HEADER_BASE)
                    hdr_base = cfg_data;
                else
                    stat_base = cfg_data;
            end
            if (result_valid) begin
                if (due_results.size() == 0) begin
                    $error("result of kind %0d arrived with no transaction outstanding", kind);
                    fault_count++;
                end
                else begin
                    want_res = due_results.pop_front();
                    cmp_field("kind", want_res.kind, kind);
                    cmp_field("slot", want_res.slot, slot);
                    cmp_field("addr", want_res.addr, addr);
                    cmp_field("length", want_res.len, length);
                    cmp_field("flags", want_res.flg, flags);
                    cmp_field("next_slot", want_res.nxt, next_slot);
                    cmp_field("req_type", want_res.rtype, req_type);
                    cmp_field("req_sector", want_res.rsec, req_sector);
                    cmp_field("ok", want_res.ok_bit, ok);
                    cmp_field("ring_index", want_res.ring, ring_index);
                    cmp_field("last", want_res.fin, last);
                end
            end
            took = start && !busy;
            if (took) begin
                predict_request(mk_cmd(func, buffer_addr, sector, is_write, head_index,
                                       used_idx, disk_status));
                if (cur_fixed)
                    due_results[due_results.size() - 1] = cur_fixed_res;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** virtqueue_desc_chain_manager: FAILED **");
            $finish;
        end
    end

    task automatic send_request(input blk_cmd_t c, input logic fx, input blk_res_t r);
        func          = c.func;
        buffer_addr   = c.buf_addr;
        sector        = c.sec;
        is_write      = c.wr;
        head_index    = c.head;
        used_idx      = c.used;
        disk_status   = c.st;
        cur_fixed     = fx;
        cur_fixed_res = r;
        start         = 1'b1;
        do
            @(negedge clk);
        while (!took);
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (due_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_bases(input logic [ADDR_W-1:0] hb, input logic [ADDR_W-1:0] sb);
        cfg_we    = 1'b1;
        cfg_index = REG_HEADER_BASE;
        cfg_data  = hb;
        @(negedge clk);
        cfg_index = REG_STATUS_BASE;
        cfg_data  = sb;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic pick_random(output blk_cmd_t c);
        int r;
        int k;
        c.buf_addr = {$urandom, $urandom};
        c.sec      = SECTOR_W'($urandom);
        c.wr       = 1'($urandom_range(1));
        c.head     = SLOT_W'($urandom);
        c.used     = RING_W'($urandom);
        c.st       = ($urandom_range(99) < 60) ? '0 : STATUS_W'($urandom);
        r = $urandom_range(99);
        if (r < 4)
            c.buf_addr = (r < 2) ? '0 : '1;
        else if (r < 8)
            c.used = (r < 6) ? '0 : '1;
        r = $urandom_range(99);
        if (r < 5) begin
            c.func = FUNC_COMPLETE;
            do
                k = $urandom_range(QUEUE_DEPTH_DEF - 1);
            while (!desc_written[k]);
            c.head = SLOT_W'(k);
        end
        else if (r < 55 || live_heads.size() == 0) begin
            c.func = FUNC_SUBMIT;
        end
        else begin
            c.func = FUNC_COMPLETE;
            k = $urandom_range(live_heads.size() - 1);
            c.head = live_heads[k];
            live_heads.delete(k);
        end
    endtask

    task automatic run_phase(input int n, input int pct);
        blk_cmd_t c;
        for (int i = 0; i < n; i++) begin
            sender_gap(pct);
            if (i == n / 2 || $urandom_range(49) == 0)
                drain_results();
            pick_random(c);
            send_request(c, 1'b0, none_res);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_HEADER_BASE;
        cfg_data     = '0;
        start        = 1'b0;
        func         = FUNC_SUBMIT;
        buffer_addr  = '0;
        sector       = '0;
        is_write     = 1'b0;
        head_index   = '0;
        used_idx     = '0;
        disk_status  = '0;
        hdr_base     = '0;
        stat_base    = '0;
        desc_free    = '1;
        desc_written = '0;
        avail_cnt    = '0;
        used_seen    = '0;
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
            desc_link[i] = '0;
            desc_mark[i] = '0;
        end
        none_res = mk_res(KIND_DESC, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0);

        add_row(mk_cmd(FUNC_SUBMIT, '0, '0, 1'b0, 3'd0, 16'h0000, 8'h00), 1'b1,
                mk_res(KIND_NOTIFY, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'd1, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, '1, 31'h7FFF_FFFF, 1'b1, 3'd7, 16'hFFFF, 8'hFF), 1'b1,
                mk_res(KIND_NOTIFY, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'd2, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, 64'h0F0F_0F0F_0F0F_0F0F, 31'h1, 1'b0, 3'd0, 16'h0, 8'h0),
                1'b1, mk_res(KIND_REFUSED, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd0, 16'hFFFF, 8'h00), 1'b1,
                mk_res(KIND_COMPLETION, 3'd0, '0, '0, '0, '0, 1'b0, '0, 1'b1, 16'hFFFF, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '1, '1, 1'b1, 3'd3, 16'h0000, 8'hFF), 1'b1,
                mk_res(KIND_COMPLETION, 3'd3, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'h0000, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, 64'h5555_5555_5555_5555, 31'h2AAA_AAAA, 1'b0, 3'd0,
                       16'h0, 8'h0), 1'b0, none_res);
        add_row(mk_cmd(FUNC_SUBMIT, 64'hAAAA_AAAA_AAAA_AAAA, 31'h5555_5555, 1'b1, 3'd0,
                       16'h0, 8'h0), 1'b0, none_res);
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd1, 16'h1234, 8'h80), 1'b1,
                mk_res(KIND_COMPLETION, 3'd1, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'h1234, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd2, 16'h4321, 8'h01), 1'b1,
                mk_res(KIND_COMPLETION, 3'd2, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'h4321, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, 64'h0123_4567_89AB_CDEF, 31'h1, 1'b0, 3'd0, 16'h0, 8'h0),
                1'b0, none_res);
        add_row(mk_cmd(FUNC_SUBMIT, '0, '0, 1'b1, 3'd0, 16'h0, 8'h0), 1'b1,
                mk_res(KIND_REFUSED, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd5, 16'h8000, 8'h00), 1'b1,
                mk_res(KIND_COMPLETION, 3'd5, '0, '0, '0, '0, 1'b0, '0, 1'b1, 16'h8000, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd0, 16'h7FFF, 8'h00), 1'b1,
                mk_res(KIND_COMPLETION, 3'd0, '0, '0, '0, '0, 1'b0, '0, 1'b1, 16'h7FFF, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd3, 16'h0001, 8'h02), 1'b1,
                mk_res(KIND_COMPLETION, 3'd3, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'h0001, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd6, 16'hFFFE, 8'h00), 1'b1,
                mk_res(KIND_COMPLETION, 3'd6, '0, '0, '0, '0, 1'b0, '0, 1'b1, 16'hFFFE, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, '0, '0, 1'b1, 3'd0, 16'h0, 8'h0), 1'b1,
                mk_res(KIND_NOTIFY, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'd6, 1'b1));
        add_row(mk_cmd(FUNC_SUBMIT, '1, 31'h7FFF_FFFF, 1'b0, 3'd0, 16'h0, 8'h0), 1'b0,
                none_res);
        add_row(mk_cmd(FUNC_SUBMIT, '1, '1, 1'b1, 3'd0, 16'h0, 8'h0), 1'b1,
                mk_res(KIND_REFUSED, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd4, 16'h0000, 8'h00), 1'b1,
                mk_res(KIND_COMPLETION, 3'd4, '0, '0, '0, '0, 1'b0, '0, 1'b1, 16'h0000, 1'b1));
        add_row(mk_cmd(FUNC_COMPLETE, '0, '0, 1'b0, 3'd0, 16'hFFFF, 8'hFF), 1'b1,
                mk_res(KIND_COMPLETION, 3'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 16'hFFFF, 1'b1));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Base addresses at their maximum, so that slot offsets wrap past 64 bits.
        set_bases('1, '1);
        foreach (dir_rows[i]) begin
            sender_gap(34);
            send_request(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].res);
        end
        drain_results();

        set_bases('0, '0);
        run_phase(145, 34);
        drain_results();

        set_bases({$urandom, $urandom}, {$urandom, $urandom});
        run_phase(145, 52);
        drain_results();

        set_bases(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        run_phase(145, 0);
        drain_results();

        repeat (12) @(negedge clk);
        if (fault_count == 0)
            $display("** virtqueue_desc_chain_manager: PASSED **");
        else
            $display("** virtqueue_desc_chain_manager: FAILED **");
        $finish;
    end

endmodule
